[rtl/core/rrac_pkg.sv]
package rrac_pkg;

    localparam int COORD_BITS  = 12;
    localparam int RADIUS_BITS = 8;
    localparam int FRAC_BITS   = 8;

    localparam int ALPHA_W = 8;
    localparam int COLOR_W = 24;

    // doubled corner offset 2*(re-xx)-1, sum of two squares
    localparam int OFS_W  = RADIUS_BITS + 1;
    localparam int SQ_W   = 2 * OFS_W + 1;
    // root of sq << (2*FRAC_BITS-2), radicand rounded up to an even width
    localparam int ROOT_W = (SQ_W + 2 * FRAC_BITS - 2 + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int RFX_W  = RADIUS_BITS + FRAC_BITS;

    // root bits resolved per pipeline stage
    localparam int SQRT_STEPS  = 3;
    localparam int SQRT_STAGES = (ROOT_W + SQRT_STEPS - 1) / SQRT_STEPS;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_RECT_LEFT   = 3'd0,
        REG_RECT_TOP    = 3'd1,
        REG_RECT_WIDTH  = 3'd2,
        REG_RECT_HEIGHT = 3'd3,
        REG_RADIUS      = 3'd4,
        REG_FILL_ALPHA  = 3'd5,
        REG_FILL_COLOR  = 3'd6,
        REG_TOP_ONLY    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
    } t_in_item;

    typedef struct packed {
        logic               covered;
        logic [ALPHA_W-1:0] pixel_alpha;
        logic [COLOR_W-1:0] pixel_color;
    } t_out_item;

    // rectangle setup with the clamped radius and far corner bounds
    typedef struct packed {
        logic [COORD_BITS-1:0]  left;
        logic [COORD_BITS-1:0]  top;
        logic [COORD_BITS-1:0]  width;
        logic [COORD_BITS-1:0]  height;
        logic [RADIUS_BITS-1:0] re;
        logic [COORD_BITS-1:0]  w_less_re;
        logic [COORD_BITS-1:0]  h_less_re;
        logic                   top_only;
    } t_geom_cfg;

    // per item flags carried alongside the root
    typedef struct packed {
        logic in_rect;
        logic corner;
    } t_side;

endpackage

[rtl/core/rounded_rect_aa_coverage_core.sv]
// Rounded rectangle coverage, one pixel query in and one coverage item out.
// 10 register stages: 2 geometry, 6 square root at up to 3 root bits each, 2 shading.
// Throughput: one item per cycle unless i_out_ready stalls a full pipeline;
// each stage holds only while the one after it is full.
// Reset (i_rst_n low, synchronous) clears the register file and all valid bits and empties the pipeline.
module rounded_rect_aa_coverage_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // pixel query channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  rrac_pkg::t_in_item                 i_in_data,
    // coverage result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output rrac_pkg::t_out_item                o_out_data,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rrac_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [rrac_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rrac_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import rrac_pkg::*;

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0]  r_rect_left;
    logic [COORD_BITS-1:0]  r_rect_top;
    logic [COORD_BITS-1:0]  r_rect_width;
    logic [COORD_BITS-1:0]  r_rect_height;
    logic [RADIUS_BITS-1:0] r_corner_radius;
    logic [ALPHA_W-1:0]     r_fill_alpha;
    logic [COLOR_W-1:0]     r_fill_color;
    logic                   r_top_only;

    // derived setup, loaded on the same edge as the registers it follows
    logic [RADIUS_BITS-1:0] r_re;
    logic [COORD_BITS-1:0]  r_w_less_re;
    logic [COORD_BITS-1:0]  r_h_less_re;

    logic                   w_cfg_wr;
    t_reg_idx               w_idx;
    logic [COORD_BITS-1:0]  n_rect_width;
    logic [COORD_BITS-1:0]  n_rect_height;
    logic [RADIUS_BITS-1:0] n_corner_radius;
    logic [RADIUS_BITS-1:0] n_re;
    logic [COORD_BITS-1:0]  w_half_w;
    logic [COORD_BITS-1:0]  w_half_h;
    t_geom_cfg              w_geom_cfg;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_idx    = t_reg_idx'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rect_left     <= '0;
            r_rect_top      <= '0;
            r_rect_width    <= '0;
            r_rect_height   <= '0;
            r_corner_radius <= '0;
            r_fill_alpha    <= '0;
            r_fill_color    <= '0;
            r_top_only      <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                REG_RECT_LEFT:   r_rect_left     <= pwdata[COORD_BITS-1:0];
                REG_RECT_TOP:    r_rect_top      <= pwdata[COORD_BITS-1:0];
                REG_RECT_WIDTH:  r_rect_width    <= pwdata[COORD_BITS-1:0];
                REG_RECT_HEIGHT: r_rect_height   <= pwdata[COORD_BITS-1:0];
                REG_RADIUS:      r_corner_radius <= pwdata[RADIUS_BITS-1:0];
                REG_FILL_ALPHA:  r_fill_alpha    <= pwdata[ALPHA_W-1:0];
                REG_FILL_COLOR:  r_fill_color    <= pwdata[COLOR_W-1:0];
                REG_TOP_ONLY:    r_top_only      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_RECT_LEFT:   prdata = APB_DATA_W'(r_rect_left);
            REG_RECT_TOP:    prdata = APB_DATA_W'(r_rect_top);
            REG_RECT_WIDTH:  prdata = APB_DATA_W'(r_rect_width);
            REG_RECT_HEIGHT: prdata = APB_DATA_W'(r_rect_height);
            REG_RADIUS:      prdata = APB_DATA_W'(r_corner_radius);
            REG_FILL_ALPHA:  prdata = APB_DATA_W'(r_fill_alpha);
            REG_FILL_COLOR:  prdata = APB_DATA_W'(r_fill_color);
            REG_TOP_ONLY:    prdata = APB_DATA_W'(r_top_only);
            default:         prdata = '0;
        endcase
    end

    // values the geometry registers hold after this edge, so the clamp is
    // ready for an item accepted right after a write
    always_comb begin
        n_rect_width    = r_rect_width;
        n_rect_height   = r_rect_height;
        n_corner_radius = r_corner_radius;
        if (w_cfg_wr && (w_idx == REG_RECT_WIDTH)) begin
            n_rect_width = pwdata[COORD_BITS-1:0];
        end
        if (w_cfg_wr && (w_idx == REG_RECT_HEIGHT)) begin
            n_rect_height = pwdata[COORD_BITS-1:0];
        end
        if (w_cfg_wr && (w_idx == REG_RADIUS)) begin
            n_corner_radius = pwdata[RADIUS_BITS-1:0];
        end
    end

    // Radius clamp: min(radius, width/2, height/2) keeps the four corner
    // squares disjoint and inside the rectangle in both modes.
    always_comb begin
        w_half_w = n_rect_width >> 1;
        w_half_h = n_rect_height >> 1;
        n_re     = n_corner_radius;
        if (COORD_BITS'(n_re) > w_half_w) begin
            n_re = w_half_w[RADIUS_BITS-1:0];
        end
        if (COORD_BITS'(n_re) > w_half_h) begin
            n_re = w_half_h[RADIUS_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_re        <= '0;
            r_w_less_re <= '0;
            r_h_less_re <= '0;
        end else begin
            r_re        <= n_re;
            r_w_less_re <= n_rect_width - COORD_BITS'(n_re);
            r_h_less_re <= n_rect_height - COORD_BITS'(n_re);
        end
    end

    always_comb begin
        w_geom_cfg.left      = r_rect_left;
        w_geom_cfg.top       = r_rect_top;
        w_geom_cfg.width     = r_rect_width;
        w_geom_cfg.height    = r_rect_height;
        w_geom_cfg.re        = r_re;
        w_geom_cfg.w_less_re = r_w_less_re;
        w_geom_cfg.h_less_re = r_h_less_re;
        w_geom_cfg.top_only  = r_top_only;
    end

    // ------------------------------------------------------------------
    // Pipeline: geometry -> square root -> shading
    // Every stage has its own valid bit; ready ripples back so a bubble
    // anywhere is filled and a stall at the output only holds full stages.
    // ------------------------------------------------------------------
    logic              w_geo_valid;
    logic              w_geo_ready;
    logic [RAD_W-1:0]  w_geo_rad;
    t_side             w_geo_side;
    logic              w_sqrt_valid;
    logic              w_sqrt_ready;
    logic [ROOT_W-1:0] w_sqrt_root;
    t_side             w_sqrt_side;

    rrac_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_geom_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_data),
        .o_valid (w_geo_valid),
        .i_ready (w_geo_ready),
        .o_rad   (w_geo_rad),
        .o_side  (w_geo_side)
    );

    // distance to the corner circle center, FRAC_BITS fraction bits
    rrac_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_geo_valid),
        .o_ready (w_geo_ready),
        .i_rad   (w_geo_rad),
        .i_side  (w_geo_side),
        .o_valid (w_sqrt_valid),
        .i_ready (w_sqrt_ready),
        .o_root  (w_sqrt_root),
        .o_side  (w_sqrt_side)
    );

    // edge test, partial alpha and the output register
    rrac_shade u_shade (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_re         (r_re),
        .i_fill_alpha (r_fill_alpha),
        .i_fill_color (r_fill_color),
        .i_valid      (w_sqrt_valid),
        .o_ready      (w_sqrt_ready),
        .i_root       (w_sqrt_root),
        .i_side       (w_sqrt_side),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_item       (o_out_data)
    );

    // an empty output register means every stage can move
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty output register");

    a_uncovered_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.covered |->
            (o_out_data.pixel_alpha == '0) && (o_out_data.pixel_color == '0))
        else $error("uncovered item carries alpha or color");

    a_radius_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(w_cfg_wr) |->
            (COORD_BITS'(r_re) <= (r_rect_width >> 1)) &&
            (COORD_BITS'(r_re) <= (r_rect_height >> 1)) &&
            (r_re <= r_corner_radius))
        else $error("radius in use exceeds its clamp");

endmodule

[rtl/core/rrac_geom.sv]
module rrac_geom (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rrac_pkg::t_geom_cfg     i_cfg,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  rrac_pkg::t_in_item      i_item,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [rrac_pkg::RAD_W-1:0] o_rad,
    output rrac_pkg::t_side         o_side
);
    import rrac_pkg::*;

    // stage A: rectangle and corner tests
    logic                   r_a_v;
    t_side                  r_a_side;
    logic [RADIUS_BITS-1:0] r_a_ox;
    logic [RADIUS_BITS-1:0] r_a_oy;
    // stage B: squared distance
    logic                   r_b_v;
    t_side                  r_b_side;
    logic [SQ_W-1:0]        r_b_sq;

    logic w_adv_a;
    logic w_adv_b;

    logic [COORD_BITS:0]    w_dx_full;
    logic [COORD_BITS:0]    w_dy_full;
    logic [COORD_BITS-1:0]  w_dx;
    logic [COORD_BITS-1:0]  w_dy;
    logic [COORD_BITS-1:0]  w_re;
    logic [COORD_BITS-1:0]  w_xx;
    logic [COORD_BITS-1:0]  w_yy;
    logic [COORD_BITS-1:0]  w_ox_full;
    logic [COORD_BITS-1:0]  w_oy_full;
    logic                   w_lo_x;
    logic                   w_lo_y;
    logic                   w_cx;
    logic                   w_cy;
    t_side                  n_a_side;

    logic [OFS_W-1:0]       w_fx2;
    logic [OFS_W-1:0]       w_fy2;
    logic [SQ_W-1:0]        n_b_sq;

    assign w_adv_b = !r_b_v || i_ready;
    assign w_adv_a = !r_a_v || w_adv_b;
    assign o_ready = w_adv_a;

    always_comb begin
        w_dx_full = {1'b0, i_item.pixel_x} - {1'b0, i_cfg.left};
        w_dy_full = {1'b0, i_item.pixel_y} - {1'b0, i_cfg.top};
        w_dx      = w_dx_full[COORD_BITS-1:0];
        w_dy      = w_dy_full[COORD_BITS-1:0];
        w_re      = COORD_BITS'(i_cfg.re);

        w_lo_x = w_dx < w_re;
        w_lo_y = w_dy < w_re;
        w_cx   = w_lo_x || (w_dx >= i_cfg.w_less_re);
        w_cy   = w_lo_y || (!i_cfg.top_only && (w_dy >= i_cfg.h_less_re));
        w_xx   = w_lo_x ? w_dx : (i_cfg.width - COORD_BITS'(1) - w_dx);
        w_yy   = w_lo_y ? w_dy : (i_cfg.height - COORD_BITS'(1) - w_dy);
        w_ox_full = w_re - w_xx;
        w_oy_full = w_re - w_yy;

        n_a_side.in_rect = !w_dx_full[COORD_BITS] && !w_dy_full[COORD_BITS]
                           && (w_dx < i_cfg.width) && (w_dy < i_cfg.height);
        n_a_side.corner  = n_a_side.in_rect && w_cx && w_cy;
    end

    always_comb begin
        w_fx2  = {r_a_ox, 1'b0} - OFS_W'(1);
        w_fy2  = {r_a_oy, 1'b0} - OFS_W'(1);
        n_b_sq = SQ_W'(w_fx2) * SQ_W'(w_fx2) + SQ_W'(w_fy2) * SQ_W'(w_fy2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (w_adv_a) begin
                r_a_v <= i_valid;
            end
            if (w_adv_b) begin
                r_b_v <= r_a_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_a && i_valid) begin
            r_a_side <= n_a_side;
            r_a_ox   <= w_ox_full[RADIUS_BITS-1:0];
            r_a_oy   <= w_oy_full[RADIUS_BITS-1:0];
        end
        if (w_adv_b && r_a_v) begin
            r_b_side <= r_a_side;
            r_b_sq   <= n_b_sq;
        end
    end

    assign o_valid = r_b_v;
    assign o_side  = r_b_side;
    assign o_rad   = RAD_W'(r_b_sq) << (2 * FRAC_BITS - 2);

endmodule

[rtl/core/rrac_sqrt.sv]
module rrac_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rrac_pkg::RAD_W-1:0]  i_rad,
    input  rrac_pkg::t_side             i_side,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rrac_pkg::ROOT_W-1:0] o_root,
    output rrac_pkg::t_side             o_side
);
    import rrac_pkg::*;

    localparam int NS = SQRT_STAGES;

    logic [NS-1:0]     r_v;
    logic [REM_W-1:0]  r_rem  [NS];
    logic [ROOT_W-1:0] r_root [NS];
    logic [RAD_W-1:0]  r_rad  [NS];
    t_side             r_side [NS];

    logic [NS-1:0]     w_adv;
    logic [NS-1:0]     w_vin;
    logic [REM_W-1:0]  w_rem_in  [NS];
    logic [ROOT_W-1:0] w_root_in [NS];
    logic [RAD_W-1:0]  w_rad_in  [NS];
    t_side             w_side_in [NS];
    logic [REM_W-1:0]  n_rem  [NS];
    logic [ROOT_W-1:0] n_root [NS];
    logic [RAD_W-1:0]  n_rad  [NS];

    always_comb begin
        w_adv[NS-1] = !r_v[NS-1] || i_ready;
        for (int s = NS - 2; s >= 0; s--) begin
            w_adv[s] = !r_v[s] || w_adv[s+1];
        end
    end

    assign o_ready = w_adv[0];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign w_vin[s]     = i_valid;
            assign w_rem_in[s]  = '0;
            assign w_root_in[s] = '0;
            assign w_rad_in[s]  = i_rad;
            assign w_side_in[s] = i_side;
        end else begin : g_next
            assign w_vin[s]     = r_v[s-1];
            assign w_rem_in[s]  = r_rem[s-1];
            assign w_root_in[s] = r_root[s-1];
            assign w_rad_in[s]  = r_rad[s-1];
            assign w_side_in[s] = r_side[s-1];
        end

        // restoring digit recurrence, one root bit per step
        always_comb begin : step
            logic [REM_W-1:0]  rem;
            logic [REM_W-1:0]  t_rem;
            logic [REM_W-1:0]  trial;
            logic [ROOT_W-1:0] root;
            logic [RAD_W-1:0]  rad;
            rem  = w_rem_in[s];
            root = w_root_in[s];
            rad  = w_rad_in[s];
            for (int j = 0; j < SQRT_STEPS; j++) begin
                if (s * SQRT_STEPS + j < ROOT_W) begin
                    t_rem = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
                    trial = {root, 2'b01};
                    if (t_rem >= trial) begin
                        rem  = t_rem - trial;
                        root = {root[ROOT_W-2:0], 1'b1};
                    end else begin
                        rem  = t_rem;
                        root = {root[ROOT_W-2:0], 1'b0};
                    end
                    rad = rad << 2;
                end
            end
            n_rem[s]  = rem;
            n_root[s] = root;
            n_rad[s]  = rad;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (w_adv[s]) begin
                r_v[s] <= w_vin[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[s] && w_vin[s]) begin
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
                r_rad[s]  <= n_rad[s];
                r_side[s] <= w_side_in[s];
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_root  = r_root[NS-1];
    assign o_side  = r_side[NS-1];

    // a finished floor root leaves a remainder no larger than twice the root
    a_root_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS-1] |-> (r_rem[NS-1] <= {1'b0, r_root[NS-1], 1'b0}))
        else $error("sqrt remainder out of range");

endmodule

[rtl/core/rrac_shade.sv]
module rrac_shade (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [rrac_pkg::RADIUS_BITS-1:0]    i_re,
    input  logic [rrac_pkg::ALPHA_W-1:0]        i_fill_alpha,
    input  logic [rrac_pkg::COLOR_W-1:0]        i_fill_color,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [rrac_pkg::ROOT_W-1:0]         i_root,
    input  rrac_pkg::t_side                     i_side,
    output logic                                o_valid,
    input  logic                                i_ready,
    output rrac_pkg::t_out_item                 o_item
);
    import rrac_pkg::*;

    localparam int PROD_W = ALPHA_W + FRAC_BITS;

    logic                 r_c_v;
    logic                 r_c_covered;
    logic                 r_c_partial;
    logic [FRAC_BITS-1:0] r_c_frac;
    logic                 r_o_v;
    t_out_item            r_o_item;

    logic              w_adv_c;
    logic              w_adv_o;
    logic [ROOT_W-1:0] w_rfx;
    logic [ROOT_W-1:0] w_diff;
    logic              w_far;
    logic [PROD_W-1:0] w_prod;
    t_out_item         n_o_item;

    assign w_adv_o = !r_o_v || i_ready;
    assign w_adv_c = !r_c_v || w_adv_o;
    assign o_ready = w_adv_c;

    // edge test: radius minus distance, both with FRAC_BITS fraction bits
    always_comb begin
        w_rfx  = ROOT_W'({i_re, {FRAC_BITS{1'b0}}});
        w_diff = w_rfx - i_root;
        w_far  = i_root >= w_rfx;
    end

    always_comb begin
        w_prod = PROD_W'(r_c_frac) * PROD_W'(i_fill_alpha);
        n_o_item = '0;
        if (r_c_covered) begin
            n_o_item.covered     = 1'b1;
            n_o_item.pixel_color = i_fill_color;
            n_o_item.pixel_alpha = r_c_partial ? w_prod[FRAC_BITS +: ALPHA_W]
                                               : i_fill_alpha;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (w_adv_c) begin
                r_c_v <= i_valid;
            end
            if (w_adv_o) begin
                r_o_v <= r_c_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_c && i_valid) begin
            r_c_covered <= i_side.in_rect && !(i_side.corner && w_far);
            r_c_partial <= i_side.corner && (w_diff >> FRAC_BITS) == '0;
            r_c_frac    <= w_diff[FRAC_BITS-1:0];
        end
        if (w_adv_o && r_c_v) begin
            r_o_item <= n_o_item;
        end
    end

    assign o_valid = r_o_v;
    assign o_item  = r_o_item;

endmodule
